[design/uesc_pkg.sv]
package uesc_pkg;

  localparam int MaxBytes = 6;
  localparam int CountWidth = $clog2(MaxBytes + 1);
  localparam int DigitCount = 3;

  typedef logic [7:0] byte_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_BSL  = 3'd1,
    PH_U    = 3'd2,
    PH_D1   = 3'd3,
    PH_D2   = 3'd4,
    PH_D3   = 3'd5
  } phase_t;

  typedef struct packed {
    byte_t [MaxBytes-1:0]  bytes;
    logic [CountWidth-1:0] count;
    logic                  last;
  } group_t;

  localparam byte_t CharBackslash = 8'h5C;
  localparam byte_t CharU         = 8'h75;
  localparam logic [15:0] OneByteMax = 16'h007F;
  localparam logic [15:0] TwoByteMax = 16'h07FF;
  localparam byte_t LeadTwo   = 8'hC0;
  localparam byte_t LeadThree = 8'hE0;
  localparam byte_t ContMark  = 8'h80;
  localparam logic [5:0] ContMask = 6'h3F;

  function automatic logic is_hex(byte_t c);
    logic r;
    r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
        (c >= 8'h41 && c <= 8'h46);
    return r;
  endfunction

  function automatic logic [3:0] hex_value(byte_t c);
    logic [3:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = c[3:0] + 4'd9;
    end else begin
      r = 4'd0;
    end
    return r;
  endfunction

  function automatic group_t push(group_t g, byte_t b);
    group_t r;
    r = g;
    if (g.count < CountWidth'(MaxBytes)) begin
      r.bytes[g.count] = b;
      r.count = g.count + CountWidth'(1);
    end
    return r;
  endfunction

  // Emits the pending escape literally: backslash, 'u' and the held digits.
  function automatic group_t flush(group_t g, phase_t ph, byte_t d0, byte_t d1, byte_t d2);
    group_t r;
    r = g;
    if (ph != PH_IDLE) begin
      r = push(r, CharBackslash);
    end
    if (ph >= PH_U) begin
      r = push(r, CharU);
    end
    if (ph >= PH_D1) begin
      r = push(r, d0);
    end
    if (ph >= PH_D2) begin
      r = push(r, d1);
    end
    if (ph == PH_D3) begin
      r = push(r, d2);
    end
    return r;
  endfunction

endpackage

[design/uesc_in_if.sv]
interface uesc_in_if;
  logic             valid;
  logic             ready;
  uesc_pkg::byte_t  in_byte;
  logic             end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

[design/uesc_out_if.sv]
interface uesc_out_if;
  logic             valid;
  logic             ready;
  uesc_pkg::byte_t  out_byte;
  logic             last_of_string;

  modport source (output valid, output out_byte, output last_of_string, input ready);
  modport sink (input valid, input out_byte, input last_of_string, output ready);
endinterface

[design/uesc_decode.sv]
module uesc_decode (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  uesc_pkg::byte_t  in_byte,
  input  logic             end_of_string,
  output uesc_pkg::group_t group
);

  uesc_pkg::phase_t phase;
  uesc_pkg::phase_t phase_next;
  uesc_pkg::byte_t  held_digits [uesc_pkg::DigitCount];
  uesc_pkg::byte_t  held_digits_next [uesc_pkg::DigitCount];
  uesc_pkg::group_t grp;
  logic             do_idle;
  logic [1:0]       dig_idx;
  logic [15:0]      code_point;

  assign dig_idx = 2'(3'(phase) - 3'(uesc_pkg::PH_U));
  assign code_point = {uesc_pkg::hex_value(held_digits[0]),
                       uesc_pkg::hex_value(held_digits[1]),
                       uesc_pkg::hex_value(held_digits[2]),
                       uesc_pkg::hex_value(in_byte)};

  always_comb begin
    grp = '0;
    phase_next = phase;
    held_digits_next = held_digits;
    do_idle = 1'b0;
    case (phase)
      uesc_pkg::PH_BSL: begin
        if (in_byte == uesc_pkg::CharU) begin
          phase_next = uesc_pkg::PH_U;
        end else begin
          grp = uesc_pkg::flush(grp, phase, held_digits[0], held_digits[1], held_digits[2]);
          do_idle = 1'b1;
        end
      end
      uesc_pkg::PH_U, uesc_pkg::PH_D1, uesc_pkg::PH_D2, uesc_pkg::PH_D3: begin
        if (!uesc_pkg::is_hex(in_byte)) begin
          grp = uesc_pkg::flush(grp, phase, held_digits[0], held_digits[1], held_digits[2]);
          do_idle = 1'b1;
        end else if (phase != uesc_pkg::PH_D3) begin
          held_digits_next[dig_idx] = in_byte;
          phase_next = uesc_pkg::phase_t'(3'(phase) + 3'd1);
        end else begin
          phase_next = uesc_pkg::PH_IDLE;
          if (code_point <= uesc_pkg::OneByteMax) begin
            grp = uesc_pkg::push(grp, code_point[7:0]);
          end else if (code_point <= uesc_pkg::TwoByteMax) begin
            grp = uesc_pkg::push(grp, uesc_pkg::LeadTwo | {3'b000, code_point[10:6]});
            grp = uesc_pkg::push(grp, uesc_pkg::ContMark |
                                 {2'b00, code_point[5:0] & uesc_pkg::ContMask});
          end else begin
            grp = uesc_pkg::push(grp, uesc_pkg::LeadThree | {4'b0000, code_point[15:12]});
            grp = uesc_pkg::push(grp, uesc_pkg::ContMark |
                                 {2'b00, code_point[11:6] & uesc_pkg::ContMask});
            grp = uesc_pkg::push(grp, uesc_pkg::ContMark |
                                 {2'b00, code_point[5:0] & uesc_pkg::ContMask});
          end
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      if (in_byte == uesc_pkg::CharBackslash) begin
        phase_next = uesc_pkg::PH_BSL;
      end else begin
        grp = uesc_pkg::push(grp, in_byte);
        phase_next = uesc_pkg::PH_IDLE;
      end
    end

    if (end_of_string) begin
      grp = uesc_pkg::flush(grp, phase_next, held_digits_next[0], held_digits_next[1],
                            held_digits_next[2]);
      grp.last = 1'b1;
      phase_next = uesc_pkg::PH_IDLE;
    end
  end

  assign group = grp;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= uesc_pkg::PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_digits <= held_digits_next;
    end
  end

endmodule

[design/uesc_outbuf.sv]
module uesc_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  uesc_pkg::group_t  group,
  output logic              free,
  uesc_out_if.source        dst
);

  uesc_pkg::byte_t              bytes [uesc_pkg::MaxBytes];
  logic [uesc_pkg::CountWidth-1:0] count;
  logic                         last;
  logic                         pop;

  assign pop = dst.valid && dst.ready;
  assign free = (count == '0) || (count == uesc_pkg::CountWidth'(1) && pop);

  assign dst.valid = (count != '0);
  assign dst.out_byte = bytes[0];
  assign dst.last_of_string = last && (count == uesc_pkg::CountWidth'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= group.count;
    end else if (pop) begin
      count <= count - uesc_pkg::CountWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= group.last;
      for (int i = 0; i < uesc_pkg::MaxBytes; i++) begin
        bytes[i] <= group.bytes[i];
      end
    end else if (pop) begin
      for (int i = 0; i < uesc_pkg::MaxBytes - 1; i++) begin
        bytes[i] <= bytes[i + 1];
      end
    end
  end

endmodule

[design/unicode_escape_to_utf8.sv]
// Decodes \uXXXX escapes in a byte stream into UTF-8 and passes other bytes through.
// The text_in channel takes one byte per transaction together with an
// end_of_string flag. The text_out channel delivers one decoded byte per
// transaction; last_of_string marks the final byte produced for a string.
// An accepted byte is decoded in the same cycle and its output bytes are
// loaded into a six-byte output buffer, so the first of them appears on
// text_out in the cycle after acceptance. Bytes that only extend a pending escape
// produce no output.
// A new byte is accepted whenever the output buffer is empty or is handing
// over its last byte, so plain text flows at one byte per cycle while the receiver
// is ready. A transaction that produces more than one output byte keeps text_in
// not ready while the buffer drains, one byte per cycle when the receiver is
// ready; a broken escape can produce up to six output bytes.
// When the receiver stalls, the buffer holds its bytes and text_in stays
// not ready once the buffer has a byte waiting.
// Reset empties the output buffer and drops any pending escape.
module unicode_escape_to_utf8 (
  input  logic        clk,
  input  logic        rst,
  uesc_in_if.sink     text_in,
  uesc_out_if.source  text_out
);

  uesc_pkg::group_t group;
  logic             free;
  logic             accept;

  assign text_in.ready = free;
  assign accept = text_in.valid && text_in.ready;

  uesc_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .in_byte       (text_in.in_byte),
    .end_of_string (text_in.end_of_string),
    .group         (group)
  );

  uesc_outbuf u_outbuf (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .group (group),
    .free  (free),
    .dst   (text_out)
  );

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !text_out.valid |-> text_in.ready)
    else $error("input not ready while output buffer is empty");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (text_out.valid && !text_out.ready) |-> !text_in.ready)
    else $error("input accepted while output byte is stalled");

  a_eos_output: assert property (@(posedge clk) disable iff (rst)
    (accept && text_in.end_of_string) |=> text_out.valid)
    else $error("end of string produced no output");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !text_out.valid)
    else $error("output valid right after reset");

endmodule

[dv/tb_top.sv]
module tb_top;

  localparam int StallLimit = 5000;
  localparam int SettleCycles = 10;
  localparam int PhaseItems = 108;

  typedef struct {
    uesc_pkg::byte_t data;
    logic            last;
  } utf8_byte_t;

  class utf8_scoreboard;
    uesc_pkg::phase_t esc_phase;
    uesc_pkg::byte_t  digit_chars[uesc_pkg::DigitCount];
    uesc_pkg::byte_t  step_bytes[$];
    utf8_byte_t       expected_bytes[$];
    int               errors;

    function new();
      esc_phase = uesc_pkg::PH_IDLE;
      foreach (digit_chars[i]) digit_chars[i] = 8'h00;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction

    function bit hex_char(uesc_pkg::byte_t c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function logic [3:0] nibble_of(uesc_pkg::byte_t c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
      return 4'(c - "A" + 10);
    endfunction

    function void emit(uesc_pkg::byte_t b);
      if (step_bytes.size() < uesc_pkg::MaxBytes) step_bytes.push_back(b);
    endfunction

    function void emit_pending_literally();
      if (esc_phase != uesc_pkg::PH_IDLE) emit(uesc_pkg::CharBackslash);
      if (int'(esc_phase) >= int'(uesc_pkg::PH_U)) emit(uesc_pkg::CharU);
      for (int i = 0; i < uesc_pkg::DigitCount; i++) begin
        if (int'(esc_phase) >= int'(uesc_pkg::PH_D1) + i) emit(digit_chars[i]);
      end
      esc_phase = uesc_pkg::PH_IDLE;
    endfunction

    function void plain_char(uesc_pkg::byte_t c);
      if (c == uesc_pkg::CharBackslash) begin
        esc_phase = uesc_pkg::PH_BSL;
      end else begin
        emit(c);
      end
    endfunction

    function void emit_utf8(logic [15:0] cp);
      if (cp <= uesc_pkg::OneByteMax) begin
        emit(cp[7:0]);
      end else if (cp <= uesc_pkg::TwoByteMax) begin
        emit(uesc_pkg::LeadTwo | {3'b000, cp[10:6]});
        emit(uesc_pkg::ContMark | {2'b00, cp[5:0] & uesc_pkg::ContMask});
      end else begin
        emit(uesc_pkg::LeadThree | {4'h0, cp[15:12]});
        emit(uesc_pkg::ContMark | {2'b00, cp[11:6] & uesc_pkg::ContMask});
        emit(uesc_pkg::ContMark | {2'b00, cp[5:0] & uesc_pkg::ContMask});
      end
    endfunction

    function void note_input(uesc_pkg::byte_t c, logic eos);
      logic [15:0] cp;
      utf8_byte_t  e;
      step_bytes.delete();
      case (esc_phase)
        uesc_pkg::PH_BSL: begin
          if (c == uesc_pkg::CharU) begin
            esc_phase = uesc_pkg::PH_U;
          end else begin
            emit_pending_literally();
            plain_char(c);
          end
        end
        uesc_pkg::PH_U, uesc_pkg::PH_D1, uesc_pkg::PH_D2: begin
          if (hex_char(c)) begin
            digit_chars[int'(esc_phase) - int'(uesc_pkg::PH_U)] = c;
            esc_phase = uesc_pkg::phase_t'(int'(esc_phase) + 1);
          end else begin
            emit_pending_literally();
            plain_char(c);
          end
        end
        uesc_pkg::PH_D3: begin
          if (hex_char(c)) begin
            cp = {nibble_of(digit_chars[0]), nibble_of(digit_chars[1]),
                  nibble_of(digit_chars[2]), nibble_of(c)};
            emit_utf8(cp);
            esc_phase = uesc_pkg::PH_IDLE;
          end else begin
            emit_pending_literally();
            plain_char(c);
          end
        end
        default: begin
          esc_phase = uesc_pkg::PH_IDLE;
          plain_char(c);
        end
      endcase
      if (eos) emit_pending_literally();
      foreach (step_bytes[k]) begin
        e.data = step_bytes[k];
        e.last = eos && (k == step_bytes.size() - 1);
        expected_bytes.push_back(e);
      end
    endfunction

    task check_output(uesc_pkg::byte_t data, logic last);
      utf8_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected output byte %02h last %0b", data, last));
      end else begin
        e = expected_bytes.pop_front();
        if (data !== e.data) begin
          report($sformatf("out_byte %02h, expected %02h", data, e.data));
        end
        if (last !== e.last) begin
          report($sformatf("last_of_string %0b, expected %0b on byte %02h",
                           last, e.last, e.data));
        end
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;
  utf8_scoreboard sb;

  uesc_in_if  text_in_if ();
  uesc_out_if text_out_if ();

  unicode_escape_to_utf8 u_top (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in_if),
    .text_out (text_out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      text_out_if.ready <= 1'b0;
    end else begin
      if (text_out_if.valid && text_out_if.ready) begin
        sb.check_output(text_out_if.out_byte, text_out_if.last_of_string);
      end
      text_out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((text_in_if.valid && text_in_if.ready) ||
                 (text_out_if.valid && text_out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("[unicode_escape_to_utf8] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input uesc_pkg::byte_t b, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      text_in_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_in_if.valid         <= 1'b1;
    text_in_if.in_byte       <= b;
    text_in_if.end_of_string <= eos;
    @(posedge clk);
    while (!text_in_if.ready) @(posedge clk);
    sb.note_input(b, eos);
  endtask

  task automatic send_string(input string s, input logic eos_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(uesc_pkg::byte_t'(s[i]), eos_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic wait_for_drain();
    text_in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic uesc_pkg::byte_t hex_digit_char(logic [3:0] n);
    if (n < 4'd10) return uesc_pkg::byte_t'("0") + uesc_pkg::byte_t'(n);
    if ($urandom_range(1) == 1) return uesc_pkg::byte_t'("a") + uesc_pkg::byte_t'(n - 4'd10);
    return uesc_pkg::byte_t'("A") + uesc_pkg::byte_t'(n - 4'd10);
  endfunction

  function automatic logic [15:0] pick_code_point();
    logic [15:0] cp;
    case ($urandom_range(4))
      0: cp = 16'($urandom_range(16'h007F));
      1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
      2: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
      3: cp = 16'($urandom_range(16'hDFFF, 16'hD800));
      default: begin
        case ($urandom_range(5))
          0: cp = 16'h0000;
          1: cp = 16'h007F;
          2: cp = 16'h0080;
          3: cp = 16'h07FF;
          4: cp = 16'h0800;
          default: cp = 16'hFFFF;
        endcase
      end
    endcase
    return cp;
  endfunction

  task automatic random_text(input int n_items);
    uesc_pkg::byte_t chunk[$];
    logic [15:0]     cp;
    int              sent;
    int              pick;
    sent = 0;
    while (sent < n_items) begin
      chunk.delete();
      pick = $urandom_range(99);
      if (pick < 60) begin
        cp = pick_code_point();
        chunk.push_back(uesc_pkg::CharBackslash);
        chunk.push_back(uesc_pkg::CharU);
        chunk.push_back(hex_digit_char(cp[15:12]));
        chunk.push_back(hex_digit_char(cp[11:8]));
        chunk.push_back(hex_digit_char(cp[7:4]));
        chunk.push_back(hex_digit_char(cp[3:0]));
        if ($urandom_range(99) < 20) begin
          case ($urandom_range(2))
            0: chunk[$urandom_range(5, 1)] = uesc_pkg::CharBackslash;
            1: chunk[$urandom_range(5, 1)] = uesc_pkg::byte_t'("g");
            default: chunk[$urandom_range(5, 1)] = uesc_pkg::byte_t'($urandom_range(255));
          endcase
        end
      end else if (pick < 70) begin
        chunk.push_back(uesc_pkg::CharBackslash);
      end else begin
        chunk.push_back(uesc_pkg::byte_t'($urandom_range(255)));
      end
      foreach (chunk[i]) begin
        send_byte(chunk[i], $urandom_range(15) == 0);
      end
      sent += chunk.size();
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    text_in_if.valid         <= 1'b0;
    text_in_if.in_byte       <= 8'h00;
    text_in_if.end_of_string <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_string("\\u0000", 1'b1);
    send_string("\\uFfFf", 1'b0);
    send_string("\\u12Az", 1'b0);
    send_string("\\u1\\", 1'b0);
    send_string("u", 1'b1);
    wait_for_drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      random_text(PhaseItems);
      wait_for_drain();
    end

    repeat (SettleCycles) @(posedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d output bytes never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("[unicode_escape_to_utf8] OK");
    end else begin
      $display("[unicode_escape_to_utf8] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/uesc_pkg.sv
design/uesc_in_if.sv
design/uesc_out_if.sv
design/uesc_decode.sv
design/uesc_outbuf.sv
design/unicode_escape_to_utf8.sv
dv/tb_top.sv
